>>> rtl/fel_pkg.sv
package fel_pkg;

  typedef enum logic [3:0] {
    M_IDLE, M_STR, M_STR_ESC, M_NUM_INT, M_NUM_FRAC, M_NUM_E, M_NUM_SIGN,
    M_NUM_EXP, M_SID, M_BID, M_BID_ESC, M_LT, M_GT
  } mode_t;

  localparam logic [4:0] K_CHAR   = 5'd0;
  localparam logic [4:0] K_END    = 5'd1;
  localparam logic [4:0] K_COLON  = 5'd2;
  localparam logic [4:0] K_CARET  = 5'd3;
  localparam logic [4:0] K_LBRACE = 5'd4;
  localparam logic [4:0] K_RBRACE = 5'd5;
  localparam logic [4:0] K_LPAREN = 5'd6;
  localparam logic [4:0] K_RPAREN = 5'd7;
  localparam logic [4:0] K_PLUS   = 5'd8;
  localparam logic [4:0] K_MINUS  = 5'd9;
  localparam logic [4:0] K_DIV    = 5'd10;
  localparam logic [4:0] K_MUL    = 5'd11;
  localparam logic [4:0] K_EQUAL  = 5'd12;
  localparam logic [4:0] K_DOLLAR = 5'd13;
  localparam logic [4:0] K_COMMA  = 5'd14;
  localparam logic [4:0] K_AMP    = 5'd15;
  localparam logic [4:0] K_LT     = 5'd16;
  localparam logic [4:0] K_NE     = 5'd17;
  localparam logic [4:0] K_LE     = 5'd18;
  localparam logic [4:0] K_GT     = 5'd19;
  localparam logic [4:0] K_GE     = 5'd20;
  localparam logic [4:0] K_STRING = 5'd21;
  localparam logic [4:0] K_NUMBER = 5'd22;
  localparam logic [4:0] K_BOOL   = 5'd23;
  localparam logic [4:0] K_IDENT  = 5'd24;
  localparam logic [4:0] K_ERROR  = 5'd25;

  localparam logic [2:0] E_NONE      = 3'd0;
  localparam logic [2:0] E_BAD_CHAR  = 3'd1;
  localparam logic [2:0] E_BAD_ESC   = 3'd2;
  localparam logic [2:0] E_UNTERM    = 3'd3;
  localparam logic [2:0] E_BAD_NUM   = 3'd4;
  localparam logic [2:0] E_EXP_DIG   = 3'd5;
  localparam logic [2:0] E_TRAIL_BSL = 3'd6;

  // one result as it travels to the output side
  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] text;
    logic       tv;
    logic       bv;
    logic [2:0] err;
  } res_t;

  // up to three results caused by one input item
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r2;
    res_t       r1;
    res_t       r0;
  } group_t;

  localparam int GW = $bits(group_t);
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

endpackage

>>> rtl/fel_front.sv
module fel_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                end_of_input,
  output logic                grp_valid,
  input  logic                grp_ready,
  output fel_pkg::group_t     grp
);

  fel_pkg::mode_t mode, mode_next;
  logic       braces, braces_next;
  logic [2:0] kpos, kpos_next;
  logic [1:0] kcand, kcand_next;
  logic       mseen, mseen_next;
  logic       hold, hold_next;

  fel_pkg::res_t rs [3];
  logic [1:0] n;

  assign in_ready  = grp_ready;
  assign grp_valid = in_valid;

  function automatic logic is_dig(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction
  function automatic logic is_alp(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic fel_pkg::res_t mk(input logic [4:0] k, input logic [7:0] t,
                                       input logic bv, input logic [2:0] e);
    fel_pkg::res_t r;
    r.kind = k;
    r.text = (k == fel_pkg::K_CHAR) ? t : 8'd0;
    r.tv   = (k == fel_pkg::K_CHAR);
    r.bv   = bv;
    r.err  = e;
    return r;
  endfunction

  always_comb begin
    logic [7:0] c, u;
    logic       restart, adv;
    logic [4:0] pk;
    logic [7:0] ft, tt;
    mode_next  = mode;
    braces_next = braces;
    kpos_next  = kpos;
    kcand_next = kcand;
    mseen_next = mseen;
    hold_next  = hold;
    rs[0] = mk(fel_pkg::K_CHAR, 8'd0, 1'b0, fel_pkg::E_NONE);
    rs[1] = rs[0];
    rs[2] = rs[0];
    n = 2'd0;
    c = in_byte;
    restart = 1'b0;
    pk = fel_pkg::K_CHAR;
    u = 8'd0; ft = 8'd0; tt = 8'd0; adv = 1'b0;

    if (end_of_input) begin
      if (!hold) begin
        case (mode)
          fel_pkg::M_STR, fel_pkg::M_STR_ESC: begin
            rs[0] = mk(fel_pkg::K_ERROR, 8'd0, 1'b0, fel_pkg::E_UNTERM); n = 2'd1;
          end
          fel_pkg::M_NUM_INT, fel_pkg::M_NUM_FRAC: begin
            rs[0] = mseen ? mk(fel_pkg::K_NUMBER, 8'd0, 1'b0, fel_pkg::E_NONE)
                          : mk(fel_pkg::K_ERROR, 8'd0, 1'b0, fel_pkg::E_BAD_NUM);
            n = 2'd1;
          end
          fel_pkg::M_NUM_E: begin
            rs[0] = mk(fel_pkg::K_ERROR, 8'd0, 1'b0, fel_pkg::E_BAD_NUM); n = 2'd1;
          end
          fel_pkg::M_NUM_SIGN: begin
            rs[0] = mk(fel_pkg::K_ERROR, 8'd0, 1'b0, fel_pkg::E_EXP_DIG); n = 2'd1;
          end
          fel_pkg::M_NUM_EXP: begin
            rs[0] = mk(fel_pkg::K_NUMBER, 8'd0, 1'b0, fel_pkg::E_NONE); n = 2'd1;
          end
          fel_pkg::M_SID, fel_pkg::M_BID: begin
            if (kcand[0] && kpos == 3'd4)
              rs[0] = mk(fel_pkg::K_BOOL, 8'd0, 1'b1, fel_pkg::E_NONE);
            else if (kcand[1] && kpos == 3'd5)
              rs[0] = mk(fel_pkg::K_BOOL, 8'd0, 1'b0, fel_pkg::E_NONE);
            else
              rs[0] = mk(fel_pkg::K_IDENT, 8'd0, 1'b0, fel_pkg::E_NONE);
            n = 2'd1;
          end
          fel_pkg::M_BID_ESC: begin
            rs[0] = mk(fel_pkg::K_ERROR, 8'd0, 1'b0, fel_pkg::E_TRAIL_BSL); n = 2'd1;
          end
          fel_pkg::M_LT: begin
            rs[0] = mk(fel_pkg::K_LT, 8'd0, 1'b0, fel_pkg::E_NONE); n = 2'd1;
          end
          fel_pkg::M_GT: begin
            rs[0] = mk(fel_pkg::K_GT, 8'd0, 1'b0, fel_pkg::E_NONE); n = 2'd1;
          end
          default: ;
        endcase
      end
      rs[n] = mk(fel_pkg::K_END, 8'd0, 1'b0, fel_pkg::E_NONE);
      n = n + 2'd1;
      mode_next = fel_pkg::M_IDLE;
      braces_next = 1'b0;
      kpos_next = 3'd0;
      kcand_next = 2'd3;
      mseen_next = 1'b0;
      hold_next = 1'b0;
    end else if (!hold) begin
      // first phase: extend or close the pending token
      case (mode)
        fel_pkg::M_STR: begin
          if (c == 8'h5c) mode_next = fel_pkg::M_STR_ESC;
          else if (c == 8'h22) begin
            mode_next = fel_pkg::M_IDLE;
            rs[0] = mk(fel_pkg::K_STRING, 8'd0, 1'b0, fel_pkg::E_NONE); n = 2'd1;
          end else begin
            rs[0] = mk(fel_pkg::K_CHAR, c, 1'b0, fel_pkg::E_NONE); n = 2'd1;
          end
        end
        fel_pkg::M_STR_ESC: begin
          mode_next = fel_pkg::M_STR;
          n = 2'd1;
          if (c == 8'h5c || c == 8'h22) rs[0] = mk(fel_pkg::K_CHAR, c, 1'b0, fel_pkg::E_NONE);
          else if (c == 8'h6e) rs[0] = mk(fel_pkg::K_CHAR, 8'h0a, 1'b0, fel_pkg::E_NONE);
          else begin
            rs[0] = mk(fel_pkg::K_ERROR, 8'd0, 1'b0, fel_pkg::E_BAD_ESC);
            mode_next = fel_pkg::M_IDLE; hold_next = 1'b1;
          end
        end
        fel_pkg::M_NUM_INT, fel_pkg::M_NUM_FRAC: begin
          n = 2'd1;
          if (is_dig(c)) begin
            mseen_next = 1'b1; rs[0] = mk(fel_pkg::K_CHAR, c, 1'b0, fel_pkg::E_NONE);
          end else if (c == 8'h2e && mode == fel_pkg::M_NUM_INT) begin
            mode_next = fel_pkg::M_NUM_FRAC;
            rs[0] = mk(fel_pkg::K_CHAR, c, 1'b0, fel_pkg::E_NONE);
          end else if (c == 8'h65 || c == 8'h45) begin
            if (!mseen) begin
              rs[0] = mk(fel_pkg::K_ERROR, 8'd0, 1'b0, fel_pkg::E_BAD_NUM);
              mode_next = fel_pkg::M_IDLE; hold_next = 1'b1;
            end else begin
              mode_next = fel_pkg::M_NUM_E;
              rs[0] = mk(fel_pkg::K_CHAR, c, 1'b0, fel_pkg::E_NONE);
            end
          end else if (!mseen) begin
            rs[0] = mk(fel_pkg::K_ERROR, 8'd0, 1'b0, fel_pkg::E_BAD_NUM);
            mode_next = fel_pkg::M_IDLE; hold_next = 1'b1;
          end else begin
            rs[0] = mk(fel_pkg::K_NUMBER, 8'd0, 1'b0, fel_pkg::E_NONE);
            mode_next = fel_pkg::M_IDLE; restart = 1'b1;
          end
        end
        fel_pkg::M_NUM_E, fel_pkg::M_NUM_SIGN: begin
          n = 2'd1;
          if (mode == fel_pkg::M_NUM_E && (c == 8'h2b || c == 8'h2d)) begin
            mode_next = fel_pkg::M_NUM_SIGN;
            rs[0] = mk(fel_pkg::K_CHAR, c, 1'b0, fel_pkg::E_NONE);
          end else if (is_dig(c)) begin
            mode_next = fel_pkg::M_NUM_EXP;
            rs[0] = mk(fel_pkg::K_CHAR, c, 1'b0, fel_pkg::E_NONE);
          end else begin
            rs[0] = mk(fel_pkg::K_ERROR, 8'd0, 1'b0, fel_pkg::E_EXP_DIG);
            mode_next = fel_pkg::M_IDLE; hold_next = 1'b1;
          end
        end
        fel_pkg::M_NUM_EXP: begin
          n = 2'd1;
          if (is_dig(c)) rs[0] = mk(fel_pkg::K_CHAR, c, 1'b0, fel_pkg::E_NONE);
          else begin
            rs[0] = mk(fel_pkg::K_NUMBER, 8'd0, 1'b0, fel_pkg::E_NONE);
            mode_next = fel_pkg::M_IDLE; restart = 1'b1;
          end
        end
        fel_pkg::M_SID, fel_pkg::M_BID, fel_pkg::M_BID_ESC: begin
          if (mode == fel_pkg::M_BID_ESC) begin
            mode_next = fel_pkg::M_BID; adv = 1'b1;
          end else if (mode == fel_pkg::M_SID) begin
            if (is_alp(c) || is_dig(c) || c == 8'h5f) adv = 1'b1;
          end else if (c == 8'h5c) begin
            mode_next = fel_pkg::M_BID_ESC;
          end else if (!(c == 8'h7d || c == 8'h3a || c == 8'h2c || c == 8'h28 || c == 8'h29))
            adv = 1'b1;
          if (adv) begin
            u = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
            case (kpos)
              3'd0: begin tt = 8'h54; ft = 8'h46; end
              3'd1: begin tt = 8'h52; ft = 8'h41; end
              3'd2: begin tt = 8'h55; ft = 8'h4c; end
              3'd3: begin tt = 8'h45; ft = 8'h53; end
              3'd4: begin tt = 8'h00; ft = 8'h45; end
              default: begin tt = 8'h00; ft = 8'h00; end
            endcase
            kcand_next = kcand;
            if (!(kpos < 3'd4 && u == tt)) kcand_next[0] = 1'b0;
            if (!(kpos < 3'd5 && u == ft)) kcand_next[1] = 1'b0;
            if (kpos < 3'd7) kpos_next = kpos + 3'd1;
            rs[0] = mk(fel_pkg::K_CHAR, c, 1'b0, fel_pkg::E_NONE); n = 2'd1;
          end else if (mode_next != fel_pkg::M_BID_ESC) begin
            if (kcand[0] && kpos == 3'd4)
              rs[0] = mk(fel_pkg::K_BOOL, 8'd0, 1'b1, fel_pkg::E_NONE);
            else if (kcand[1] && kpos == 3'd5)
              rs[0] = mk(fel_pkg::K_BOOL, 8'd0, 1'b0, fel_pkg::E_NONE);
            else
              rs[0] = mk(fel_pkg::K_IDENT, 8'd0, 1'b0, fel_pkg::E_NONE);
            n = 2'd1; mode_next = fel_pkg::M_IDLE; restart = 1'b1;
          end
        end
        fel_pkg::M_LT: begin
          mode_next = fel_pkg::M_IDLE; n = 2'd1;
          if (c == 8'h3e) rs[0] = mk(fel_pkg::K_NE, 8'd0, 1'b0, fel_pkg::E_NONE);
          else if (c == 8'h3d) rs[0] = mk(fel_pkg::K_LE, 8'd0, 1'b0, fel_pkg::E_NONE);
          else begin rs[0] = mk(fel_pkg::K_LT, 8'd0, 1'b0, fel_pkg::E_NONE); restart = 1'b1; end
        end
        fel_pkg::M_GT: begin
          mode_next = fel_pkg::M_IDLE; n = 2'd1;
          if (c == 8'h3d) rs[0] = mk(fel_pkg::K_GE, 8'd0, 1'b0, fel_pkg::E_NONE);
          else begin rs[0] = mk(fel_pkg::K_GT, 8'd0, 1'b0, fel_pkg::E_NONE); restart = 1'b1; end
        end
        default: begin mode_next = fel_pkg::M_IDLE; restart = 1'b1; end
      endcase

      // second phase: the byte starts a new token
      if (restart) begin
        case (c)
          8'h3a: begin pk = fel_pkg::K_COLON; braces_next = 1'b0; end
          8'h5e: pk = fel_pkg::K_CARET;
          8'h7b: begin pk = fel_pkg::K_LBRACE; braces_next = 1'b1; end
          8'h7d: begin pk = fel_pkg::K_RBRACE; braces_next = 1'b0; end
          8'h28: pk = fel_pkg::K_LPAREN;
          8'h29: pk = fel_pkg::K_RPAREN;
          8'h2b: pk = fel_pkg::K_PLUS;
          8'h2d: pk = fel_pkg::K_MINUS;
          8'h2f: pk = fel_pkg::K_DIV;
          8'h2a: pk = fel_pkg::K_MUL;
          8'h3d: pk = fel_pkg::K_EQUAL;
          8'h24: pk = fel_pkg::K_DOLLAR;
          8'h2c: pk = fel_pkg::K_COMMA;
          8'h26: pk = fel_pkg::K_AMP;
          default: pk = fel_pkg::K_CHAR;
        endcase
        if (c == 8'h20 || (c >= 8'd9 && c <= 8'd13)) begin
        end else if (pk != fel_pkg::K_CHAR) begin
          rs[n] = mk(pk, 8'd0, 1'b0, fel_pkg::E_NONE); n = n + 2'd1;
        end else if (c == 8'h22) mode_next = fel_pkg::M_STR;
        else if (!braces && (is_dig(c) || c == 8'h2e)) begin
          mseen_next = is_dig(c);
          mode_next = is_dig(c) ? fel_pkg::M_NUM_INT : fel_pkg::M_NUM_FRAC;
          rs[n] = mk(fel_pkg::K_CHAR, c, 1'b0, fel_pkg::E_NONE); n = n + 2'd1;
        end else if (c == 8'h3c) mode_next = fel_pkg::M_LT;
        else if (c == 8'h3e) mode_next = fel_pkg::M_GT;
        else if (braces && c == 8'h5c) begin
          kpos_next = 3'd0; kcand_next = 2'd3; mode_next = fel_pkg::M_BID_ESC;
        end else if (braces || is_alp(c)) begin
          // first identifier character: only position zero is possible
          u = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
          kpos_next = 3'd1;
          kcand_next = {u == 8'h46, u == 8'h54};
          mode_next = braces ? fel_pkg::M_BID : fel_pkg::M_SID;
          rs[n] = mk(fel_pkg::K_CHAR, c, 1'b0, fel_pkg::E_NONE); n = n + 2'd1;
        end else begin
          rs[n] = mk(fel_pkg::K_ERROR, 8'd0, 1'b0, fel_pkg::E_BAD_CHAR); n = n + 2'd1;
          mode_next = fel_pkg::M_IDLE; hold_next = 1'b1;
        end
      end
    end
    grp.cnt = n;
    grp.r0 = rs[0];
    grp.r1 = rs[1];
    grp.r2 = rs[2];
  end

  // lexer state advances on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= fel_pkg::M_IDLE;
      braces <= 1'b0;
      kpos <= 3'd0;
      kcand <= 2'd3;
      mseen <= 1'b0;
      hold <= 1'b0;
    end else if (in_valid && grp_ready) begin
      mode <= mode_next;
      braces <= braces_next;
      kpos <= kpos_next;
      kcand <= kcand_next;
      mseen <= mseen_next;
      hold <= hold_next;
    end
  end

endmodule

>>> rtl/fel_queue.sv
module fel_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_valid,
  output logic                       wr_ready,
  input  logic [fel_pkg::GW-1:0]     wr_data,
  output logic                       rd_valid,
  input  logic                       rd_ready,
  output logic [fel_pkg::GW-1:0]     rd_data
);

  logic [fel_pkg::GW-1:0] mem [fel_pkg::QDEPTH];
  logic [fel_pkg::QAW-1:0] wp, rp;
  logic [fel_pkg::QAW:0] cnt;
  logic wr_en, rd_en;

  assign wr_ready = cnt != fel_pkg::QDEPTH[fel_pkg::QAW:0];
  assign rd_valid = cnt != '0;
  assign rd_data  = mem[rp];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr_en) wp <= wp + 1'b1;
      if (rd_en) rp <= rp + 1'b1;
      cnt <= cnt + {{fel_pkg::QAW{1'b0}}, wr_en} - {{fel_pkg::QAW{1'b0}}, rd_en};
    end
  end

endmodule

>>> rtl/fel_back.sv
module fel_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              grp_valid,
  output logic              grp_ready,
  input  fel_pkg::group_t   grp,
  output logic              out_valid,
  input  logic              out_ready,
  output fel_pkg::res_t     out_res,
  output logic              out_last
);

  logic [1:0] idx;
  fel_pkg::res_t cur;
  logic is_last, take;

  // empty groups drop at once; otherwise step through the results
  always_comb begin
    case (idx)
      2'd0: cur = grp.r0;
      2'd1: cur = grp.r1;
      default: cur = grp.r2;
    endcase
  end

  assign is_last = (idx + 2'd1 == grp.cnt);
  assign take = !out_valid || out_ready;
  assign grp_ready = (grp.cnt == 2'd0) || (take && is_last);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= 2'd0;
    end else if (take) begin
      if (grp_valid && grp.cnt != 2'd0) begin
        out_valid <= 1'b1;
        idx <= is_last ? 2'd0 : idx + 2'd1;
      end else out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= cur;
      out_last <= is_last;
    end
  end

endmodule

>>> rtl/formula_expression_lexer.sv
// Formula lexer, one source byte per input item.
// s_axis: tdata[7:0] = in_byte, tuser = end_of_input (end mark, byte ignored).
// m_axis: one item per result; tdata packs text_byte, text_valid, bool_value,
// error_code; tuser = token_kind; tlast = last result caused by an input item.
// An input byte yields zero to two results; the end mark always yields the
// end token last. After an error every byte is dropped until the end mark.
// Throughput: one input item per cycle while each yields at most one result
// and the receiver does not stall; the output side moves one result per
// cycle while the receiver accepts. Each item passes a four-entry queue
// between the classifier and the output sequencer, then the output register.
// The classifier forms results combinationally from its state; the queue lets
// input keep flowing while the receiver stalls; tready drops once it is full.
// Synchronous reset returns the lexer to idle between tokens and empties the
// queue and the output register.
module formula_expression_lexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // in_byte
  input  logic        s_axis_tuser,  // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // text_byte, text_valid, bool_value, error_code, 3'b0
  output logic [4:0]  m_axis_tuser,  // token_kind
  output logic        m_axis_tlast   // last
);

  logic f_valid, f_ready, q_valid, q_ready;
  fel_pkg::group_t f_grp, q_grp;
  logic [fel_pkg::GW-1:0] q_data;
  fel_pkg::res_t res;

  fel_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata), .end_of_input(s_axis_tuser),
    .grp_valid(f_valid), .grp_ready(f_ready), .grp(f_grp)
  );

  fel_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_grp),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  assign q_grp = q_data;

  fel_back u_back (
    .clk(clk), .rst(rst),
    .grp_valid(q_valid), .grp_ready(q_ready), .grp(q_grp),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_res(res), .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, res.err, res.bv, res.tv, res.text};
  assign m_axis_tuser = res.kind;

endmodule
